// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- hdl/cltb_pkg.sv -----
// ----------------------------------------------------------------------------
// cltb_pkg
// Shared types and constants for the circular log tail buffer.
// ----------------------------------------------------------------------------
package cltb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REQ_W  = 16;

  // operation codes of an input word
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic append;     // write byte, bump index and count
    logic load_read;  // latch clamped length and start address
    logic fetch;      // read one byte from the ring, step the address
    logic advance;    // one byte delivered, bump the step counter
  } cltb_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic op_read;    // incoming word is a read
    logic n_zero;     // incoming read returns no bytes
    logic last;       // current output word is the last of the read
  } cltb_sts_t;

endpackage

// ----- hdl/cltb_if.sv -----
// ----------------------------------------------------------------------------
// cltb_if
// Handshake channels of the log buffer: command input and result output.
// ----------------------------------------------------------------------------
interface cltb_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [cltb_pkg::BYTE_W-1:0]      byte_in;
  logic [cltb_pkg::REQ_W-1:0]       request_len;

  modport source (output valid, operation, byte_in, request_len, input ready);
  modport sink   (input valid, operation, byte_in, request_len, output ready);
endinterface

interface cltb_out_if #(
  parameter int unsigned CNT_W = 7
);
  logic                             valid;
  logic                             ready;
  logic [cltb_pkg::BYTE_W-1:0]      byte_out;
  logic                             byte_valid;
  logic                             last;
  logic [CNT_W-1:0]                 returned_count;
  logic [CNT_W-1:0]                 held_count;
  logic                             has_wrapped;

  modport source (output valid, byte_out, byte_valid, last, returned_count, held_count,
                  has_wrapped, input ready);
  modport sink   (input valid, byte_out, byte_valid, last, returned_count, held_count,
                  has_wrapped, output ready);
endinterface

// ----- hdl/cltb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cltb_ctrl
// Sequencer of the log buffer: takes words, drives the readout of one read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cltb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cltb_pkg::cltb_sts_t sts_i,
  output cltb_pkg::cltb_cmd_t cmd_o
);
  import cltb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_SEND  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_fire, out_fire;

  // handshakes
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SEND);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // datapath commands
  assign cmd_o.append    = in_fire && !sts_i.op_read;
  assign cmd_o.load_read = in_fire && sts_i.op_read;
  assign cmd_o.fetch     = (state_q == S_FETCH) || (out_fire && !sts_i.last);
  assign cmd_o.advance   = out_fire && !sts_i.last;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && sts_i.op_read) begin
          state_d = sts_i.n_zero ? S_SEND : S_FETCH;
        end
      end
      S_FETCH: state_d = S_SEND;
      S_SEND: begin
        if (out_fire && sts_i.last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "input taken during readout")
  `ASSERT_AT(a_last_frees, clk_i, rst_ni, out_fire && sts_i.last |=> in_ready_o, "not idle after last word")
  `ASSERT_AT(a_fetch_then_send, clk_i, rst_ni, state_q == S_FETCH |=> out_valid_o, "fetch not followed by send")

endmodule

// ----- hdl/cltb_datapath.sv -----
// ----------------------------------------------------------------------------
// cltb_datapath
// Ring memory, write index, saturating written count and readout counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cltb_datapath #(
  parameter int unsigned RING_BYTES = 64,
  parameter int unsigned IDX_W      = $clog2(RING_BYTES),
  parameter int unsigned CNT_W      = $clog2(RING_BYTES + 2)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cltb_pkg::cltb_cmd_t           cmd_i,
  output cltb_pkg::cltb_sts_t           sts_o,
  input  logic                          operation_i,
  input  logic [cltb_pkg::BYTE_W-1:0]   byte_in_i,
  input  logic [cltb_pkg::REQ_W-1:0]    request_len_i,
  output logic [cltb_pkg::BYTE_W-1:0]   byte_out_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [CNT_W-1:0]              returned_count_o,
  output logic [CNT_W-1:0]              held_count_o,
  output logic                          has_wrapped_o
);
  import cltb_pkg::*;

  localparam int unsigned CMP_W = CNT_W + REQ_W;
  localparam int unsigned SUB_W = CNT_W + 1;

  logic [BYTE_W-1:0] log_mem [RING_BYTES];

  logic [IDX_W-1:0]  wr_idx_q, rd_addr_q;
  logic [CNT_W-1:0]  written_q, count_q, step_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic              byte_valid_q;

  logic [CNT_W-1:0]  held;
  logic              wrapped;
  logic [CMP_W-1:0]  req_ext, held_ext;
  logic [CNT_W-1:0]  n_len;
  logic [SUB_W-1:0]  start_diff, start_fix;
  logic [IDX_W-1:0]  rd_addr_nxt;

  // held bytes and wrap flag from the saturating count
  assign wrapped = (written_q > CNT_W'(RING_BYTES));
  assign held    = wrapped ? CNT_W'(RING_BYTES) : written_q;

  // clamp the request to the held count
  assign req_ext  = CMP_W'(request_len_i);
  assign held_ext = CMP_W'(held);
  assign n_len    = (req_ext < held_ext) ? CNT_W'(req_ext) : held;

  // oldest returned byte sits n bytes behind the write index
  assign start_diff = SUB_W'(wr_idx_q) - SUB_W'(n_len);
  assign start_fix  = start_diff[SUB_W-1] ? (start_diff + SUB_W'(RING_BYTES)) : start_diff;

  assign rd_addr_nxt = (rd_addr_q == IDX_W'(RING_BYTES - 1)) ? '0 : (rd_addr_q + IDX_W'(1));

  // status to the controller
  assign sts_o.op_read = (operation_i == OP_READ);
  assign sts_o.n_zero  = (n_len == '0);
  assign sts_o.last    = (count_q == '0) || ((step_q + CNT_W'(1)) == count_q);

  // result word
  assign byte_out_o       = byte_valid_q ? rd_data_q : '0;
  assign byte_valid_o     = byte_valid_q;
  assign last_o           = sts_o.last;
  assign returned_count_o = count_q;
  assign held_count_o     = held;
  assign has_wrapped_o    = wrapped;

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      log_mem[wr_idx_q] <= byte_in_i;
    end
    if (cmd_i.fetch) begin
      rd_data_q <= log_mem[rd_addr_q];
    end
  end

  // write side: index and saturating count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      written_q <= '0;
    end else if (cmd_i.append) begin
      wr_idx_q <= (wr_idx_q == IDX_W'(RING_BYTES - 1)) ? '0 : (wr_idx_q + IDX_W'(1));
      if (written_q != CNT_W'(RING_BYTES + 1)) begin
        written_q <= written_q + CNT_W'(1);
      end
    end
  end

  // read side: address, returned count, step within the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q    <= '0;
      count_q      <= '0;
      step_q       <= '0;
      byte_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_read) begin
        rd_addr_q    <= IDX_W'(start_fix);
        count_q      <= n_len;
        step_q       <= '0;
        byte_valid_q <= (n_len != '0);
      end else if (cmd_i.fetch) begin
        rd_addr_q <= rd_addr_nxt;
      end
      if (cmd_i.advance) begin
        step_q <= step_q + CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_written_sat, clk_i, rst_ni, written_q > CNT_W'(RING_BYTES + 1), "written count past saturation")
  `ASSERT_AT(a_step_in_run, clk_i, rst_ni, count_q != '0 |-> step_q < count_q, "readout step beyond run")
  `ASSERT_AT(a_status_empty, clk_i, rst_ni, !byte_valid_q |-> count_q == '0, "status word with nonzero count")

endmodule

// ----- hdl/circular_log_tail_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// circular_log_tail_buffer_unit
// Byte log ring that overwrites its oldest bytes and returns its newest tail.
// ----------------------------------------------------------------------------
// Appends stream at one per cycle while no read is in progress.
// After a read word is taken, the FETCH state uses the single read port of
// the ring to fetch the first byte, after which bytes leave at one per cycle
// while the sink is ready; a status-only read (zero request or empty ring)
// skips the FETCH state. No new input word is taken until the last word of a
// read has been delivered.

module circular_log_tail_buffer_unit #(
  parameter int unsigned RING_BYTES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cltb_in_if.sink         item_i,
  cltb_out_if.source      result_o
);
  import cltb_pkg::*;

  localparam int unsigned IDX_W = $clog2(RING_BYTES);
  localparam int unsigned CNT_W = $clog2(RING_BYTES + 2);

  cltb_cmd_t cmd;
  cltb_sts_t sts;

  // sequencer
  cltb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ring and counters
  cltb_datapath #(
    .RING_BYTES (RING_BYTES),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (item_i.operation),
    .byte_in_i        (item_i.byte_in),
    .request_len_i    (item_i.request_len),
    .byte_out_o       (result_o.byte_out),
    .byte_valid_o     (result_o.byte_valid),
    .last_o           (result_o.last),
    .returned_count_o (result_o.returned_count),
    .held_count_o     (result_o.held_count),
    .has_wrapped_o    (result_o.has_wrapped)
  );

endmodule

// ----- tb/cltb_tail_checker.sv -----
// ----------------------------------------------------------------------------
// cltb_tail_checker
// Watches both channels of the log buffer, predicts every result word and
// compares it field by field.
// ----------------------------------------------------------------------------
// Keeps its own copy of the ring: byte store, write index and saturating
// write count. Each accepted append updates that copy. Each accepted read
// queues the result words it should produce. Each accepted result word is
// checked against the oldest queued word.

module cltb_tail_checker #(
  parameter int unsigned RING_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cltb_in_if          item_mon,
  cltb_out_if         result_mon,
  output int unsigned mismatch_count_o,
  output int unsigned words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cltb_pkg::*;

  localparam int unsigned CNT_W     = $clog2(RING_BYTES + 2);
  localparam int unsigned IDX_W     = $clog2(RING_BYTES);
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              byte_valid;
    logic              last;
    logic [CNT_W-1:0]  returned_count;
    logic [CNT_W-1:0]  held_count;
    logic              has_wrapped;
  } tail_word_t;

  // mirrored ring state
  logic [BYTE_W-1:0] ring_mem [RING_BYTES];
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  write_total;   // saturates at RING_BYTES + 1

  tail_word_t  tail_words_q[$];
  int unsigned fault_cnt;

  function automatic string word_text(tail_word_t w);
    return $sformatf("byte=%02h bv=%0b last=%0b ret=%0d held=%0d wrap=%0b",
                     w.byte_out, w.byte_valid, w.last, w.returned_count,
                     w.held_count, w.has_wrapped);
  endfunction

  task automatic log_append(input logic [BYTE_W-1:0] b);
    ring_mem[wr_idx] = b;
    wr_idx = IDX_W'((int'(wr_idx) + 1) % RING_BYTES);
    if (write_total < CNT_W'(RING_BYTES + 1)) write_total++;
  endtask

  // queue the words a read returns: newest min(req, held) bytes, oldest first
  task automatic predict_tail_read(input logic [REQ_W-1:0] req);
    int unsigned held;
    int unsigned n;
    int unsigned first;
    logic        wrapped;
    tail_word_t  w;
    wrapped = (write_total > CNT_W'(RING_BYTES));
    held    = wrapped ? RING_BYTES : int'(write_total);
    n       = (int'(req) < held) ? int'(req) : held;
    w.held_count     = CNT_W'(held);
    w.has_wrapped    = wrapped;
    w.returned_count = CNT_W'(n);
    if (n == 0) begin
      // status only: zero request or empty ring
      w.byte_out   = '0;
      w.byte_valid = 1'b0;
      w.last       = 1'b1;
      tail_words_q.push_back(w);
    end else begin
      first = wrapped ? (int'(wr_idx) + RING_BYTES - n) % RING_BYTES : held - n;
      for (int unsigned k = 0; k < n; k++) begin
        w.byte_out   = ring_mem[(first + k) % RING_BYTES];
        w.byte_valid = 1'b1;
        w.last       = (k + 1 == n);
        tail_words_q.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tail_word_t seen;
    tail_word_t want;
    logic       bad;
    if (!rst_ni) begin
      wr_idx      = '0;
      write_total = '0;
      tail_words_q.delete();
      fault_cnt   = 0;
    end else begin
      // result side first: a word leaving now belongs to an older read
      if (result_mon.valid && result_mon.ready) begin
        seen.byte_out       = result_mon.byte_out;
        seen.byte_valid     = result_mon.byte_valid;
        seen.last           = result_mon.last;
        seen.returned_count = result_mon.returned_count;
        seen.held_count     = result_mon.held_count;
        seen.has_wrapped    = result_mon.has_wrapped;
        if (tail_words_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MAX_SHOWN)
            $display("%t: result word with none outstanding: %s", $realtime,
                     word_text(seen));
        end else begin
          want = tail_words_q.pop_front();
          bad  = (seen.byte_out !== want.byte_out) ||
                 (seen.byte_valid !== want.byte_valid) ||
                 (seen.last !== want.last) ||
                 (seen.returned_count !== want.returned_count) ||
                 (seen.held_count !== want.held_count) ||
                 (seen.has_wrapped !== want.has_wrapped);
          if (bad) begin
            fault_cnt++;
            if (fault_cnt <= MAX_SHOWN)
              $display("%t: result mismatch\n  expected %s\n  actual   %s", $realtime,
                       word_text(want), word_text(seen));
          end
        end
      end
      // input side
      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.operation == OP_APPEND) log_append(item_mon.byte_in);
        else predict_tail_read(item_mon.request_len);
      end
    end
    mismatch_count_o <= fault_cnt;
    words_due_o      <= tail_words_q.size();
  end

endmodule

// ----- tb/circular_log_tail_buffer_unit_test.sv -----
// ----------------------------------------------------------------------------
// circular_log_tail_buffer_unit_test
// Regression for the circular log tail buffer.
// ----------------------------------------------------------------------------
// Drives append and read words into the block in bursts with random gaps,
// while the result sink stalls on its own shifting pattern. A directed opening
// covers the empty ring, zero and oversized requests and field extremes; the
// random part fills and wraps the ring and reads tails of every length. The
// checker beside the block predicts and compares each result word.

module circular_log_tail_buffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cltb_pkg::*;

  localparam int unsigned RING_BYTES   = 64;
  localparam int unsigned CNT_W        = $clog2(RING_BYTES + 2);
  localparam int unsigned RANDOM_WORDS = 360;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef enum logic [1:0] {
    SINK_OPEN,        // always ready
    SINK_COIN,        // ready on a coin flip
    SINK_EVERY_THIRD, // stall whenever the phase is a multiple of three
    SINK_BURSTY       // long stall, short open window
  } sink_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned words_due;

  cltb_in_if                        item_if ();
  cltb_out_if #(.CNT_W(CNT_W))      result_if ();

  circular_log_tail_buffer_unit #(
    .RING_BYTES(RING_BYTES)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  cltb_tail_checker #(
    .RING_BYTES(RING_BYTES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_mon        (item_if),
    .result_mon      (result_if),
    .mismatch_count_o(mismatch_count),
    .words_due_o     (words_due)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result sink: stall pattern changes after a random run length
  sink_mode_e  sink_mode;
  int unsigned sink_left;
  int unsigned sink_phase;

  initial begin
    result_if.ready = 1'b0;
    sink_left       = 0;
    sink_phase      = 0;
    sink_mode       = SINK_OPEN;
  end

  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(8, 90);
    end
    sink_left--;
    sink_phase++;
    case (sink_mode)
      SINK_OPEN:        result_if.ready <= 1'b1;
      SINK_COIN:        result_if.ready <= ($urandom_range(0, 1) == 1);
      SINK_EVERY_THIRD: result_if.ready <= (sink_phase % 3 != 0);
      default:          result_if.ready <= (sink_phase % 16 >= 12);
    endcase
  end

  // watchdog: cycles in which no word moves on either channel
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((item_if.valid && item_if.ready) ||
                 (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d result words due",
               IDLE_LIMIT, words_due);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // sender state
  int unsigned burst_left;
  int unsigned appended;
  logic        last_was_append;

  // one input word; called and returns at a falling edge
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] b,
                           input logic [REQ_W-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    item_if.valid       <= 1'b1;
    item_if.operation   <= op;
    item_if.byte_in     <= b;
    item_if.request_len <= len;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (op == OP_APPEND) appended++;
    last_was_append = (op == OP_APPEND);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned held;
    int unsigned pick;
    logic        op;
    logic [REQ_W-1:0] len;

    item_if.valid       = 1'b0;
    item_if.operation   = OP_APPEND;
    item_if.byte_in     = '0;
    item_if.request_len = '0;
    burst_left          = 0;
    appended            = 0;
    last_was_append     = 1'b0;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty ring, zero and oversized requests, field extremes
    send_word(OP_READ,   8'h00, 16'd0);
    send_word(OP_READ,   8'hFF, 16'd7);
    send_word(OP_READ,   8'h00, 16'hFFFF);
    send_word(OP_APPEND, 8'h00, 16'hFFFF);
    send_word(OP_READ,   8'h00, 16'd1);
    send_word(OP_APPEND, 8'hFF, 16'd0);
    send_word(OP_APPEND, 8'h5A, 16'hAAAA);
    send_word(OP_APPEND, 8'hA5, 16'h5555);
    send_word(OP_READ,   8'hFF, 16'd0);
    send_word(OP_READ,   8'h00, 16'd2);
    send_word(OP_READ,   8'h00, 16'd4);
    send_word(OP_READ,   8'h00, 16'hFFFF);
    send_word(OP_READ,   8'h00, 16'(RING_BYTES + 1));
    send_word(OP_READ,   8'h00, 16'h8000);
    send_word(OP_APPEND, 8'h80, 16'h0000);
    send_word(OP_APPEND, 8'h01, 16'hFFFF);
    send_word(OP_READ,   8'h00, 16'd3);

    // random: mostly appends until well past wrap, reads of every length
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      held = (appended > RING_BYTES) ? RING_BYTES : appended;
      len  = 16'($urandom);
      if (last_was_append && appended + 1 >= RING_BYTES && appended <= RING_BYTES + 1) begin
        // read right at full and just-wrapped
        op  = OP_READ;
        len = 16'($urandom_range(RING_BYTES - 1, RING_BYTES + 1));
      end else if ($urandom_range(0, 99) < 70) begin
        op = OP_APPEND;
      end else begin
        op   = OP_READ;
        pick = $urandom_range(0, 99);
        if (pick < 5)       len = '0;
        else if (pick < 55) len = 16'($urandom_range(1, (held > 0) ? held : 1));
        else if (pick < 65) len = 16'(held);
        else if (pick < 75) len = 16'(RING_BYTES);
        else if (pick < 85) len = 16'($urandom_range(held + 1, 255));
      end
      send_word(op, 8'($urandom), len);
    end
    item_if.valid <= 1'b0;

    // drain, then leave room for a stray word
    while (words_due != 0) @(negedge clk_i);
    repeat (RING_BYTES + 8) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
